/* sv/scc_pkg.sv */
// Shared types and constants for the sample change capture block.
// No dependencies.
package scc_pkg;

  localparam int unsigned LEN_W    = 17;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 9;

  localparam logic [LEN_W-1:0]   LENGTH_RESET = 17'd4000;
  localparam logic [LEN_W-1:0]   LENGTH_MAX   = 17'd65536;
  localparam logic [COUNT_W-1:0] MAX_CHANGES  = 9'd256;

  localparam logic KIND_CHANGE  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // One queue entry: everything one sample produces (change and/or summary).
  typedef struct packed {
    logic                has_change;
    logic                has_summary;
    logic [OFFSET_W-1:0] offset;
    logic [SAMPLE_W-1:0] value;
    logic [TIME_W-1:0]   start;
    logic [COUNT_W-1:0]  count;
    logic                ovf;
  } scc_entry_t;

endpackage

/* sv/scc_front.sv */
// Front part: takes samples, tracks block state, classifies each sample.
// Depends on scc_pkg.
module scc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [scc_pkg::SAMPLE_W-1:0] sample,
  input  logic                         cfg_valid,
  input  logic [scc_pkg::LEN_W-1:0]    cfg_length,
  input  logic                         full,
  output logic                         push,
  output scc_pkg::scc_entry_t          push_entry
);

  logic [scc_pkg::LEN_W-1:0]    block_length;
  logic [scc_pkg::SAMPLE_W-1:0] prev_sample;
  logic [scc_pkg::OFFSET_W-1:0] offset_counter;
  logic [scc_pkg::COUNT_W-1:0]  stored_changes;
  logic                         overflow_flag;
  logic [scc_pkg::TIME_W-1:0]   block_base;

  logic [scc_pkg::LEN_W-1:0]   eff_len;
  logic                        accept;
  logic                        is_change;
  logic                        room;
  logic                        rec_change;
  logic                        block_end;
  logic [scc_pkg::COUNT_W-1:0] stored_next;
  logic                        overflow_next;

  always_comb begin
    if (block_length == '0) begin
      eff_len = scc_pkg::LEN_W'(1);
    end else if (block_length > scc_pkg::LENGTH_MAX) begin
      eff_len = scc_pkg::LENGTH_MAX;
    end else begin
      eff_len = block_length;
    end
  end

  assign in_ready      = !full;
  assign accept        = in_valid && !full;
  assign is_change     = (sample != prev_sample);
  assign room          = (stored_changes < scc_pkg::MAX_CHANGES);
  assign rec_change    = is_change && room;
  assign overflow_next = overflow_flag | (is_change & ~room);
  assign stored_next   = stored_changes + scc_pkg::COUNT_W'(rec_change);
  assign block_end     = ({1'b0, offset_counter} + scc_pkg::LEN_W'(1)) >= eff_len;

  assign push = accept && (rec_change || block_end);

  always_comb begin
    push_entry.has_change  = rec_change;
    push_entry.has_summary = block_end;
    push_entry.offset      = offset_counter;
    push_entry.value       = sample;
    push_entry.start       = block_base;
    push_entry.count       = stored_next;
    push_entry.ovf         = overflow_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length   <= scc_pkg::LENGTH_RESET;
      prev_sample    <= '0;
      offset_counter <= '0;
      stored_changes <= '0;
      overflow_flag  <= 1'b0;
      block_base     <= '0;
    end else begin
      if (cfg_valid) begin
        block_length <= cfg_length;
      end
      if (accept) begin
        prev_sample <= sample;
        if (block_end) begin
          block_base     <= block_base + scc_pkg::TIME_W'(eff_len);
          offset_counter <= '0;
          stored_changes <= '0;
          overflow_flag  <= 1'b0;
        end else begin
          offset_counter <= offset_counter + scc_pkg::OFFSET_W'(1);
          stored_changes <= stored_next;
          overflow_flag  <= overflow_next;
        end
      end
    end
  end

endmodule

/* sv/scc_fifo.sv */
// Short queue of classified entries between front and back parts.
// Depends on scc_pkg.
module scc_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  scc_pkg::scc_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output scc_pkg::scc_entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  scc_pkg::scc_entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  logic do_push;
  logic do_pop;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

/* sv/scc_back.sv */
// Back part: expands queue entries into change and summary records,
// held in an output register. Depends on scc_pkg.
module scc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         empty,
  input  scc_pkg::scc_entry_t          head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         record_kind,
  output logic [scc_pkg::OFFSET_W-1:0] change_offset,
  output logic [scc_pkg::SAMPLE_W-1:0] change_value,
  output logic [scc_pkg::TIME_W-1:0]   block_start,
  output logic [scc_pkg::COUNT_W-1:0]  change_count,
  output logic                         overflowed,
  output logic                         last
);

  logic change_sent;  // head's change record already issued, summary pending
  logic load;
  logic emit_change;

  assign load        = (!out_valid || out_ready) && !empty;
  assign emit_change = head.has_change && !change_sent;
  assign pop         = load && !(emit_change && head.has_summary);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      change_sent <= 1'b0;
    end else begin
      if (load) begin
        out_valid   <= 1'b1;
        change_sent <= emit_change && head.has_summary;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_change) begin
        record_kind   <= scc_pkg::KIND_CHANGE;
        change_offset <= head.offset;
        change_value  <= head.value;
        block_start   <= '0;
        change_count  <= '0;
        overflowed    <= 1'b0;
        last          <= 1'b0;
      end else begin
        record_kind   <= scc_pkg::KIND_SUMMARY;
        change_offset <= '0;
        change_value  <= '0;
        block_start   <= head.start;
        change_count  <= head.count;
        overflowed    <= head.ovf;
        last          <= 1'b1;
      end
    end
  end

endmodule

/* sv/sample_change_capture.sv */
// Sample change capture: one 32-bit sample per transfer in, change records
// and block summaries out. A record passes a queue write, then an output
// register load. Throughput: one sample per cycle while the queue has room;
// records leave one per cycle while out_ready is high, so a change plus a
// summary from one sample makes two records, absorbed by the QUEUE_DEPTH
// queue. Reset (rst, synchronous) clears block state, empties the queue, length 4000.
module sample_change_capture #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  // sample channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [scc_pkg::SAMPLE_W-1:0] sample,
  // block length register write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [scc_pkg::LEN_W-1:0]    block_length,
  // record channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         record_kind,
  output logic [scc_pkg::OFFSET_W-1:0] change_offset,
  output logic [scc_pkg::SAMPLE_W-1:0] change_value,
  output logic [scc_pkg::TIME_W-1:0]   block_start,
  output logic [scc_pkg::COUNT_W-1:0]  change_count,
  output logic                         overflowed,
  output logic                         last
);

  // Register writes are always taken; the user must send them only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  logic                push;
  logic                full;
  logic                pop;
  logic                empty;
  scc_pkg::scc_entry_t push_entry;
  scc_pkg::scc_entry_t head;

  // Front: per-block offset, change count, overflow flag and start time.
  // Each sample that yields any record becomes one queue entry.
  scc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .cfg_valid  (cfg_valid),
    .cfg_length (block_length),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue decouples the sample side from output backpressure.
  scc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .head       (head)
  );

  // Back: change record first, then the summary when the entry ends a block.
  scc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .record_kind   (record_kind),
    .change_offset (change_offset),
    .change_value  (change_value),
    .block_start   (block_start),
    .change_count  (change_count),
    .overflowed    (overflowed),
    .last          (last)
  );

endmodule
